### design/ptt_pkg.sv
// Package for the periodic timer table: channel item types, operation codes
// and sequencer states. Used by the top level; depends on nothing.
package ptt_pkg;

  localparam int unsigned ID_W = 5;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] period;
    logic [4:0]  del_id;
  } cmd_t;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] id_out;
    logic            fired;
    logic            last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_CALC,
    ST_TICK_END,
    ST_ADD_SCAN,
    ST_RESP
  } state_t;

endpackage

### design/ptt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the period and elapsed count of each timer slot; no dependencies.
module ptt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ptt_step.sv
// Shared update unit: advances one timer's elapsed count and decides whether
// it expires. Used by the tick sweep of the top level; no package needed.
module ptt_step #(
  parameter int unsigned PW = 16
) (
  input  logic [PW-1:0] elapsed,
  input  logic [PW-1:0] period,
  output logic          fire,
  output logic [PW-1:0] elapsed_next
);

  logic [PW-1:0] elapsed_inc;

  // The count wraps at the period width, as the stored field does.
  assign elapsed_inc  = elapsed + PW'(1);
  assign fire         = (elapsed_inc >= period);
  assign elapsed_next = fire ? '0 : elapsed_inc;

endmodule

### design/periodic_timer_table.sv
// Top level of the periodic timer table: sequencer, slot valid bits and
// output register. Depends on ptt_pkg, ptt_ram and ptt_step.
//
// Usage. Commands arrive on cmd (valid/ready): tick, add or delete. Each
// command gives one or more items on rsp (valid/ready), the final one
// marked by last. An add answers with the lowest free id or an error; a
// delete answers ok or error; a tick answers with one item per expired
// timer in ascending id order, or a single quiet item when none expires.
// cfg (valid/ready, always ready) writes the capacity register.
// Sequencing: one command at a time. A delete or rejected add answers from
// ST_RESP; an accepted add scans the valid bits one slot a cycle from the
// lowest id. A tick sweeps every slot through the one update unit and the
// slot RAM: a free slot is passed over in ST_TICK_RD, an active one is read
// there and updated in ST_TICK_CALC, since the RAM read is registered;
// ST_TICK_END then closes the sweep.
// A new command is taken as soon as the previous one has handed its last
// item to the output register, even while that item waits to be taken.
// When rsp stalls the sweep holds until the output register frees.
// Reset clears all slots, the active count and the output valid flag, and
// sets capacity to 16; no clearing pass is needed.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int unsigned MAX_TIMERS  = 16,
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int unsigned PW    = PERIOD_BITS;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TIMERS - 1);

  state_t                 state, state_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [MAX_TIMERS-1:0]  slot_valid, slot_valid_next;
  logic [CNT_W-1:0]       active_count, active_count_next;
  logic [CAP_W-1:0]       capacity;
  logic [PW-1:0]          add_period, add_period_next;
  logic                   pend_valid, pend_valid_next;
  logic [ID_W-1:0]        pend_id, pend_id_next;
  rsp_t                   resp, resp_next;
  rsp_t                   rsp_next;
  logic                   rsp_valid_next;
  logic                   push;

  logic                   ram_we;
  logic [2*PW-1:0]        ram_wdata, ram_rdata;
  logic [PW-1:0]          rd_period, rd_elapsed, elapsed_next;
  logic                   fire;

  logic [PW-1:0]          cmd_period;
  logic [IDX_W-1:0]       del_idx;
  logic                   del_hit;
  logic                   can_push;
  logic [ID_W-1:0]        idx_id;

  ptt_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign rd_period  = ram_rdata[2*PW-1:PW];
  assign rd_elapsed = ram_rdata[PW-1:0];

  ptt_step #(
    .PW (PW)
  ) u_step (
    .elapsed      (rd_elapsed),
    .period       (rd_period),
    .fire         (fire),
    .elapsed_next (elapsed_next)
  );

  assign cmd_ready  = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign can_push   = !rsp_valid || rsp_ready;
  assign cmd_period = PW'(cmd.period);
  assign del_idx    = IDX_W'(5'(cmd.del_id - 5'd1));
  assign del_hit    = (cmd.del_id != '0) && (32'(cmd.del_id) <= MAX_TIMERS)
                      && slot_valid[del_idx];
  assign idx_id     = ID_W'(32'(idx) + 1);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    slot_valid_next   = slot_valid;
    active_count_next = active_count;
    add_period_next   = add_period;
    pend_valid_next   = pend_valid;
    pend_id_next      = pend_id;
    resp_next         = resp;
    push              = 1'b0;
    rsp_next          = rsp;
    ram_we            = 1'b0;
    ram_wdata         = {rd_period, elapsed_next};

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          idx_next  = '0;
          resp_next = '{status: STATUS_ERR, id_out: '0, fired: 1'b0, last: 1'b1};
          case (cmd.mode)
            MODE_TICK: begin
              pend_valid_next = 1'b0;
              state_next      = ST_TICK_RD;
            end
            MODE_ADD: begin
              add_period_next = cmd_period;
              if (cmd_period == '0 || 32'(active_count) >= 32'(capacity)) begin
                state_next = ST_RESP;
              end else begin
                state_next = ST_ADD_SCAN;
              end
            end
            MODE_DEL: begin
              if (del_hit) begin
                slot_valid_next[del_idx] = 1'b0;
                if (active_count != '0) begin
                  active_count_next = active_count - CNT_W'(1);
                end
                resp_next.status = STATUS_OK;
              end
              state_next = ST_RESP;
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end

      ST_TICK_RD: begin
        // The read address is idx, so the slot's entry is ready next cycle.
        if (slot_valid[idx]) begin
          state_next = ST_TICK_CALC;
        end else if (idx == IDX_LAST) begin
          state_next = ST_TICK_END;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end

      ST_TICK_CALC: begin
        // A held expiry is only released once a later one proves it is not last.
        if (!(fire && pend_valid && !can_push)) begin
          ram_we = 1'b1;
          if (fire) begin
            if (pend_valid) begin
              push     = 1'b1;
              rsp_next = '{status: STATUS_OK, id_out: pend_id, fired: 1'b1, last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_id_next    = idx_id;
          end
          if (idx == IDX_LAST) begin
            state_next = ST_TICK_END;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ST_TICK_RD;
          end
        end
      end

      ST_TICK_END: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_valid) begin
            rsp_next = '{status: STATUS_OK, id_out: pend_id, fired: 1'b1, last: 1'b1};
          end else begin
            rsp_next = '{status: STATUS_OK, id_out: '0, fired: 1'b0, last: 1'b1};
          end
          state_next = ST_IDLE;
        end
      end

      ST_ADD_SCAN: begin
        if (!slot_valid[idx]) begin
          ram_we               = 1'b1;
          ram_wdata            = {add_period, PW'(0)};
          slot_valid_next[idx] = 1'b1;
          active_count_next    = active_count + CNT_W'(1);
          resp_next            = '{status: STATUS_OK, id_out: idx_id, fired: 1'b0,
                                   last: 1'b1};
          state_next           = ST_RESP;
        end else if (idx == IDX_LAST) begin
          state_next = ST_RESP;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end

      ST_RESP: begin
        if (can_push) begin
          push       = 1'b1;
          rsp_next   = resp;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (push) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_valid   <= '0;
      active_count <= '0;
      capacity     <= CAP_RESET;
      pend_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      slot_valid   <= slot_valid_next;
      active_count <= active_count_next;
      pend_valid   <= pend_valid_next;
      rsp_valid    <= rsp_valid_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    add_period <= add_period_next;
    pend_id    <= pend_id_next;
    resp       <= resp_next;
    rsp        <= rsp_next;
  end

  // The count of active timers always agrees with the valid bits.
  assert property (@(posedge clk) disable iff (rst)
    32'(active_count) == 32'($countones(slot_valid)))
    else $error("active count disagrees with slot valid bits");

  // An item is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (!rsp_valid || rsp_ready))
    else $error("output item overwritten before it was taken");

  // Only zero-free periods reach the slot scan.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_SCAN) |-> (add_period != '0))
    else $error("slot scan started with a zero period");

  // An expiry item always reports success.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.fired) |-> (rsp.status == STATUS_OK && rsp.id_out != '0))
    else $error("expiry item with error status or no id");

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output valid after reset");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_table: random and directed timer commands
// are checked against a cycle-free model of the timer table.
// Depends on ptt_pkg and the periodic_timer_table RTL.
module tb
  import ptt_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int PER_W = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_t             cmd = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  periodic_timer_table #(
    .MAX_TIMERS (SLOTS),
    .PERIOD_BITS(PER_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Model of the timer table, updated when a command is accepted.
  logic             tt_valid [SLOTS];
  logic [PER_W-1:0] tt_period [SLOTS];
  logic [PER_W-1:0] tt_elapsed [SLOTS];
  int unsigned      tt_active = 0;
  logic [CAP_W-1:0] tt_capacity = CAP_RESET;

  cmd_t cmd_q[$];
  rsp_t rsp_expected_q[$];

  int tx_idle_max = 17;
  int rx_idle_max = 17;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;

  int cmds_accepted = 0;
  int rsps_checked = 0;
  int expiries_seen = 0;
  int fail_count = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tt_valid[i] = 1'b0;
      tt_period[i] = '0;
      tt_elapsed[i] = '0;
    end
  end

  function automatic void push_rsp(logic status, int id, logic fired, logic last);
    rsp_t r;
    r.status = status;
    r.id_out = ID_W'(id);
    r.fired = fired;
    r.last = last;
    rsp_expected_q.push_back(r);
  endfunction

  function automatic void timer_table_apply(input cmd_t c);
    logic [SLOTS-1:0] fire_mask;
    int               free_slot;
    fire_mask = '0;
    free_slot = -1;
    case (c.mode)
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tt_valid[i]) begin
            tt_elapsed[i] = tt_elapsed[i] + 1'b1;
            if (tt_elapsed[i] >= tt_period[i]) begin
              tt_elapsed[i] = '0;
              fire_mask[i] = 1'b1;
            end
          end
        end
        if (fire_mask == '0) begin
          push_rsp(STATUS_OK, 0, 1'b0, 1'b1);
        end else begin
          // Ascending id order; the highest fired slot closes the tick.
          for (int i = 0; i < SLOTS; i++) begin
            if (fire_mask[i]) begin
              push_rsp(STATUS_OK, i + 1, 1'b1, (fire_mask >> (i + 1)) == '0);
            end
          end
        end
      end
      MODE_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tt_valid[i]) begin
            free_slot = i;
          end
        end
        if (c.period == '0 || tt_active >= tt_capacity || free_slot < 0) begin
          push_rsp(STATUS_ERR, 0, 1'b0, 1'b1);
        end else begin
          tt_valid[free_slot] = 1'b1;
          tt_period[free_slot] = c.period;
          tt_elapsed[free_slot] = '0;
          tt_active++;
          push_rsp(STATUS_OK, free_slot + 1, 1'b0, 1'b1);
        end
      end
      MODE_DEL: begin
        if (c.del_id >= 1 && c.del_id <= SLOTS && tt_valid[c.del_id - 1]) begin
          tt_valid[c.del_id - 1] = 1'b0;
          if (tt_active > 0) begin
            tt_active--;
          end
          push_rsp(STATUS_OK, 0, 1'b0, 1'b1);
        end else begin
          push_rsp(STATUS_ERR, 0, 1'b0, 1'b1);
        end
      end
      default: begin
        push_rsp(STATUS_ERR, 0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Command driver: a gap is drawn after each accepted item.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_wait = 0;
    end else if (!cmd_valid || cmd_ready) begin
      if (cmd_valid) begin
        timer_table_apply(cmd);
        cmds_accepted++;
        send_wait = $urandom_range(0, tx_idle_max);
      end
      if (send_wait > 0) begin
        send_wait--;
        cmd_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd <= cmd_q.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  function automatic void report_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      fail_count++;
    end
  endfunction

  // Response monitor with random stalls and one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_expected_q.size() == 0) begin
          $display("%0t: unexpected response, actual status %0d id %0d fired %0d last %0d",
                   $time, rsp.status, rsp.id_out, rsp.fired, rsp.last);
          fail_count++;
        end else begin
          rsp_t e;
          e = rsp_expected_q.pop_front();
          report_field("status", e.status, rsp.status);
          report_field("id_out", e.id_out, rsp.id_out);
          report_field("fired", e.fired, rsp.fired);
          report_field("last", e.last, rsp.last);
        end
        rsps_checked++;
        if (rsp.fired) begin
          expiries_seen++;
        end
        recv_wait = $urandom_range(0, rx_idle_max);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= (recv_wait == 0);
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] mode, int period, int id);
    cmd_t c;
    c.mode = mode;
    c.period = PER_W'(period);
    c.del_id = 5'(id);
    return c;
  endfunction

  function automatic cmd_t random_cmd(int tick_pct, int add_pct);
    int   r;
    int   p;
    int   id;
    logic [1:0] mode;
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      mode = MODE_TICK;
    end else if (r < tick_pct + add_pct) begin
      mode = MODE_ADD;
    end else if (r < 97) begin
      mode = MODE_DEL;
    end else begin
      mode = MODE_UNUSED;
    end
    // Short periods keep expiries frequent; a few zero and full-range ones.
    case ($urandom_range(0, 9))
      0: p = 0;
      1: p = $urandom_range(0, 16'hFFFF);
      2: p = 16'hFFFF;
      default: p = $urandom_range(1, 6);
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) begin
      id = 0;
    end else if (r == 1) begin
      id = $urandom_range(SLOTS + 1, 31);
    end else begin
      id = $urandom_range(1, SLOTS);
    end
    return make_cmd(mode, p, id);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || cmd_valid || rsp_expected_q.size() != 0);
    repeat (SLOTS * 3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    tt_capacity = value;
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int count, int tick_pct, int add_pct,
                           int tx_max, int rx_max);
    write_capacity(cap);
    tx_idle_max <= tx_max;
    rx_idle_max <= rx_max;
    repeat (count) cmd_q.push_back(random_cmd(tick_pct, add_pct));
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    write_capacity(CAP_RESET);

    // Directed: quiet tick, rejected and accepted adds, bad deletes, unused mode.
    cmd_q.push_back(make_cmd(MODE_TICK, 0, 0));
    cmd_q.push_back(make_cmd(MODE_ADD, 0, 0));
    cmd_q.push_back(make_cmd(MODE_ADD, 1, 0));
    cmd_q.push_back(make_cmd(MODE_ADD, 16'hFFFF, 31));
    cmd_q.push_back(make_cmd(MODE_ADD, 2, 0));
    cmd_q.push_back(make_cmd(MODE_ADD, 16'h8000, 0));
    cmd_q.push_back(make_cmd(MODE_DEL, 0, 0));
    cmd_q.push_back(make_cmd(MODE_DEL, 0, 31));
    cmd_q.push_back(make_cmd(MODE_DEL, 0, SLOTS));
    cmd_q.push_back(make_cmd(MODE_DEL, 16'hFFFF, 2));
    cmd_q.push_back(make_cmd(MODE_DEL, 0, 2));
    cmd_q.push_back(make_cmd(MODE_UNUSED, 16'hFFFF, 31));
    cmd_q.push_back(make_cmd(MODE_TICK, 16'hFFFF, 31));
    cmd_q.push_back(make_cmd(MODE_TICK, 0, 0));
    cmd_q.push_back(make_cmd(MODE_TICK, 0, 0));
    cmd_q.push_back(make_cmd(MODE_ADD, 3, 0));
    cmd_q.push_back(make_cmd(MODE_TICK, 0, 0));
    cmd_q.push_back(make_cmd(MODE_TICK, 0, 0));
    wait_drained();

    // Tight and zero capacity, then a capacity beyond the slot count to fill the table.
    run_phase(5'd1, 30, 30, 45, 17, 17);
    run_phase(5'd0, 20, 30, 50, 17, 17);
    run_phase(5'd31, 70, 30, 55, 17, 17);

    // The receiver holds off while commands keep coming back to back.
    write_capacity(5'(SLOTS));
    tx_idle_max <= 0;
    rx_idle_max <= 17;
    hold_request <= 1'b1;
    repeat (60) cmd_q.push_back(random_cmd(60, 25));
    wait_drained();

    run_phase(5'($urandom_range(1, SLOTS)), 60, 35, 40, 17, 17);
    run_phase(5'($urandom_range(1, SLOTS - 1)), 50, 40, 35, 17, 0);
    run_phase(5'(SLOTS), 40, 45, 35, 0, 0);

    repeat (20) @(posedge clk);
    $display("Ran %0d commands giving %0d responses, %0d of them timer expiries,",
             cmds_accepted, rsps_checked, expiries_seen);
    $display("over capacities 0, 1, 16, 31 and random, with stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout with %0d responses still expected.", rsp_expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
